// ===== hw/rtl/pbrle_pkg.sv =====
package pbrle_pkg;

  localparam int unsigned MAX_CHUNK  = 128;
  localparam int unsigned LIT_DEPTH  = 256;
  localparam int unsigned LIT_AW     = $clog2(LIT_DEPTH);
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned OUTQ_DEPTH = 2;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int unsigned WORD_BYTES = 8;

  typedef logic [LIT_AW:0] lit_ptr_t;

  // one item's worth of work for the back end, in emission order
  typedef struct packed {
    logic       pre_run;
    logic [7:0] pre_len;
    logic [7:0] pre_val;
    logic [7:0] lit_len;
    logic       post_run;
    logic [7:0] post_len;
    logic [7:0] cur_val;
    logic       pad;
    logic       seg_end;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [LIT_AW-1:0] addr;
    logic [7:0]        data;
  } lit_wr_t;

  typedef struct packed {
    logic [7:0] data;
    logic       item_end;
    logic       seg_end;
  } byte_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  count;
    logic        burst_last;
    logic        segment_done;
  } res_t;

endpackage

// ===== hw/rtl/packbits_rle_segment_encoder.sv =====
// input: one byte per cycle while the literal buffer and the 4-deep command queue have room
// output: the back end sends one encoded byte per cycle while the output queue has room,
//   and takes each command in its idle state, sending no byte while it does so
// reset: rst_ni is asynchronous, active low, clears run state, pointers and queues;
//   the 256-entry literal buffer is not cleared and needs no clearing pass
module packbits_rle_segment_encoder import pbrle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        segment_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_word_o,
  output logic [3:0]  out_count_o,
  output logic        burst_last_o,
  output logic        segment_done_o
);

  lit_wr_t           lit_wr;
  lit_ptr_t          lit_head;
  logic [LIT_AW-1:0] lit_rd_addr;
  logic [7:0]        lit_rd_data;
  logic              cmd_push;
  logic              cmd_full;
  cmd_t              cmd_in;
  cmd_t              cmd_out;
  logic              cmd_empty;
  logic              cmd_pop;
  logic              byte_valid;
  byte_t             byte_w;
  logic              byte_ready;
  res_t              res;

  pbrle_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .segment_last_i (segment_last_i),
    .lit_head_i     (lit_head),
    .lit_wr_o       (lit_wr),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in),
    .cmd_full_i     (cmd_full)
  );

  pbrle_lit_buf u_lit_buf (
    .clk_i     (clk_i),
    .wr_i      (lit_wr),
    .rd_addr_i (lit_rd_addr),
    .rd_data_o (lit_rd_data)
  );

  pbrle_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (cmd_push),
    .cmd_i  (cmd_in),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .cmd_o  (cmd_out),
    .empty  (cmd_empty)
  );

  pbrle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_out),
    .cmd_empty_i   (cmd_empty),
    .cmd_pop_o     (cmd_pop),
    .lit_rd_addr_o (lit_rd_addr),
    .lit_rd_data_i (lit_rd_data),
    .lit_head_o    (lit_head),
    .byte_valid_o  (byte_valid),
    .byte_o        (byte_w),
    .byte_ready_i  (byte_ready)
  );

  pbrle_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_w),
    .byte_ready_o (byte_ready),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res)
  );

  assign out_word_o     = res.word;
  assign out_count_o    = res.count;
  assign burst_last_o   = res.burst_last;
  assign segment_done_o = res.segment_done;

  a_cmd_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("command pushed into a full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_count_o != 4'd0) && (out_count_o <= 4'(WORD_BYTES)))
    else $error("result byte count out of range");

  a_partial_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (out_count_o != 4'(WORD_BYTES)) |-> burst_last_o)
    else $error("partial word that does not close its burst");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && segment_done_o |-> burst_last_o)
    else $error("segment closed inside a burst");

endmodule

// ===== hw/rtl/pbrle_lit_buf.sv =====
module pbrle_lit_buf import pbrle_pkg::*; (
  input  logic              clk_i,
  input  lit_wr_t           wr_i,
  input  logic [LIT_AW-1:0] rd_addr_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0] mem [LIT_DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

// ===== hw/rtl/pbrle_front.sv =====
module pbrle_front import pbrle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       segment_last_i,
  input  lit_ptr_t   lit_head_i,
  output lit_wr_t    lit_wr_o,
  output logic       cmd_push_o,
  output cmd_t       cmd_o,
  input  logic       cmd_full_i
);

  logic       has_prev_q, has_prev_d;
  logic [7:0] prev_q, prev_d;
  logic [7:0] run_q, run_d;
  logic [7:0] fill_q, fill_d;
  logic       parity_q, parity_d;
  lit_ptr_t   tail_q, tail_d;

  lit_ptr_t    used;
  logic        room;
  logic        accept;
  logic        eq;
  logic [8:0]  run_inc;
  logic [8:0]  fill_sum;
  logic [1:0]  commit_a;
  logic        commit_l;
  logic        pre_run;
  logic [7:0]  pre_len;
  logic [7:0]  lit_a;
  logic [7:0]  run_a;
  logic [7:0]  fill_a;
  lit_ptr_t    tail_a;
  logic        wr_en;
  logic [LIT_AW-1:0] wr_addr;
  logic        post_run;
  logic [8:0]  lit_total;
  logic        parity_n;
  logic        pad;
  logic        has_bytes;

  // two speculative copies of the current byte may sit just past the tail
  assign used   = tail_q - lit_head_i;
  assign room   = used <= lit_ptr_t'(LIT_DEPTH - 3);
  assign full   = cmd_full_i || !room;
  assign accept = push && !full;

  always_comb begin
    eq       = has_prev_q && (data_byte_i == prev_q);
    run_inc  = {1'b0, run_q} + 9'd1;
    fill_sum = {1'b0, fill_q};
    commit_a = 2'd0;
    pre_run  = 1'b0;
    pre_len  = '0;
    lit_a    = '0;
    run_a    = run_q;
    fill_a   = fill_q;
    tail_a   = tail_q;
    wr_en    = 1'b0;
    wr_addr  = tail_q[LIT_AW-1:0];

    if (eq) begin
      if (run_inc == 9'd2) begin
        // second copy, kept in case the pair ends up as literals
        wr_en   = 1'b1;
        wr_addr = LIT_AW'(tail_q + 1'b1);
      end
      if (run_inc > 9'd2 && fill_q != '0) begin
        lit_a  = fill_q;
        fill_a = '0;
        run_a  = run_inc[7:0];
      end else if (run_inc > 9'(MAX_CHUNK)) begin
        pre_run = 1'b1;
        pre_len = 8'(MAX_CHUNK);
        run_a   = 8'(run_inc - 9'(MAX_CHUNK));
      end else begin
        run_a = run_inc[7:0];
      end
    end else begin
      if (run_q == 8'd1) begin
        commit_a = 2'd1;
      end else if (run_q == 8'd2) begin
        commit_a = 2'd2;
      end
      if (run_q >= 8'd3) begin
        pre_run = 1'b1;
        pre_len = run_q;
      end
      fill_sum = {1'b0, fill_q} + 9'(commit_a);
      if (fill_sum > 9'(MAX_CHUNK)) begin
        lit_a  = 8'(MAX_CHUNK);
        fill_a = 8'(fill_sum - 9'(MAX_CHUNK));
      end else begin
        fill_a = fill_sum[7:0];
      end
      tail_a  = tail_q + lit_ptr_t'(commit_a);
      wr_en   = 1'b1;
      wr_addr = tail_a[LIT_AW-1:0];
      run_a   = 8'd1;
    end

    commit_l = segment_last_i && (run_a == 8'd1);
    post_run = segment_last_i && (run_a >= 8'd2);
    if (segment_last_i) begin
      lit_total = {1'b0, lit_a} + {1'b0, fill_a} + 9'(commit_l);
    end else begin
      lit_total = {1'b0, lit_a};
    end
    // each literal chunk adds its bytes plus one header; runs add two
    parity_n  = parity_q ^ lit_total[0] ^
                ((lit_total != '0) && (lit_total <= 9'(MAX_CHUNK)));
    pad       = segment_last_i && parity_n;
    has_bytes = pre_run || (lit_total != '0) || post_run || pad;
  end

  always_comb begin
    cmd_o.pre_run  = pre_run;
    cmd_o.pre_len  = pre_len;
    cmd_o.pre_val  = prev_q;
    cmd_o.lit_len  = lit_total[7:0];
    cmd_o.post_run = post_run;
    cmd_o.post_len = run_a;
    cmd_o.cur_val  = data_byte_i;
    cmd_o.pad      = pad;
    cmd_o.seg_end  = segment_last_i;
  end

  assign cmd_push_o    = accept && has_bytes;
  assign lit_wr_o.en   = accept && wr_en;
  assign lit_wr_o.addr = wr_addr;
  assign lit_wr_o.data = eq ? prev_q : data_byte_i;

  always_comb begin
    has_prev_d = has_prev_q;
    prev_d     = prev_q;
    run_d      = run_q;
    fill_d     = fill_q;
    parity_d   = parity_q;
    tail_d     = tail_q;
    if (accept) begin
      prev_d = data_byte_i;
      if (segment_last_i) begin
        has_prev_d = 1'b0;
        run_d      = '0;
        fill_d     = '0;
        parity_d   = 1'b0;
        tail_d     = tail_a + lit_ptr_t'(commit_l);
      end else begin
        has_prev_d = 1'b1;
        run_d      = run_a;
        fill_d     = fill_a;
        parity_d   = parity_n;
        tail_d     = tail_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_prev_q <= 1'b0;
      prev_q     <= '0;
      run_q      <= '0;
      fill_q     <= '0;
      parity_q   <= 1'b0;
      tail_q     <= '0;
    end else begin
      has_prev_q <= has_prev_d;
      prev_q     <= prev_d;
      run_q      <= run_d;
      fill_q     <= fill_d;
      parity_q   <= parity_d;
      tail_q     <= tail_d;
    end
  end

endmodule

// ===== hw/rtl/pbrle_cmd_fifo.sv =====
module pbrle_cmd_fifo import pbrle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  input  cmd_t cmd_i,
  output logic full,
  input  logic pop,
  output cmd_t cmd_o,
  output logic empty
);

  cmd_t entry_q [CMDQ_DEPTH];
  logic [CMDQ_AW:0] wr_q, wr_d;
  logic [CMDQ_AW:0] rd_q, rd_d;
  logic [CMDQ_AW:0] level;

  assign level = wr_q - rd_q;
  assign full  = level == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign empty = level == '0;
  assign cmd_o = entry_q[rd_q[CMDQ_AW-1:0]];

  assign wr_d = (push && !full) ? wr_q + 1'b1 : wr_q;
  assign rd_d = (pop && !empty) ? rd_q + 1'b1 : rd_q;

  always_ff @(posedge clk_i) begin
    if (push && !full) begin
      entry_q[wr_q[CMDQ_AW-1:0]] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

endmodule

// ===== hw/rtl/pbrle_back.sv =====
module pbrle_back import pbrle_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output logic [LIT_AW-1:0] lit_rd_addr_o,
  input  logic [7:0]        lit_rd_data_i,
  output lit_ptr_t          lit_head_o,
  output logic              byte_valid_o,
  output byte_t             byte_o,
  input  logic              byte_ready_i
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_PRE_HDR  = 8'b0000_0010,
    ST_PRE_VAL  = 8'b0000_0100,
    ST_LIT_HDR  = 8'b0000_1000,
    ST_LIT_DATA = 8'b0001_0000,
    ST_POST_HDR = 8'b0010_0000,
    ST_POST_VAL = 8'b0100_0000,
    ST_PAD      = 8'b1000_0000
  } seq_state_e;

  localparam logic [7:0] PAD_BYTE = 8'h00;

  seq_state_e state_q, state_d, nxt;
  cmd_t       cmd_q, cmd_d;
  logic [7:0] lit_rem_q, lit_rem_d;
  logic [7:0] chunk_rem_q, chunk_rem_d;
  lit_ptr_t   head_q, head_d;
  logic [7:0] chunk;
  logic [7:0] data;
  logic       advance;

  function automatic logic [7:0] run_header(input logic [7:0] len);
    run_header = 8'(9'd257 - {1'b0, len});
  endfunction

  function automatic seq_state_e phase_from(input logic pre, input logic lits,
                                            input logic post, input logic pad);
    seq_state_e s;
    if (pre) begin
      s = ST_PRE_HDR;
    end else if (lits) begin
      s = ST_LIT_HDR;
    end else if (post) begin
      s = ST_POST_HDR;
    end else if (pad) begin
      s = ST_PAD;
    end else begin
      s = ST_IDLE;
    end
    phase_from = s;
  endfunction

  assign chunk   = (lit_rem_q > 8'(MAX_CHUNK)) ? 8'(MAX_CHUNK) : lit_rem_q;
  assign advance = byte_valid_o && byte_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    lit_rem_d   = lit_rem_q;
    chunk_rem_d = chunk_rem_q;
    head_d      = head_q;
    cmd_pop_o   = 1'b0;
    byte_valid_o = 1'b1;
    data        = PAD_BYTE;
    nxt         = ST_IDLE;
    unique case (state_q)
      ST_IDLE: begin
        byte_valid_o = 1'b0;
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          lit_rem_d = cmd_i.lit_len;
          state_d   = phase_from(cmd_i.pre_run, cmd_i.lit_len != '0,
                                 cmd_i.post_run, cmd_i.pad);
        end
      end
      ST_PRE_HDR: begin
        data = run_header(cmd_q.pre_len);
        nxt  = ST_PRE_VAL;
      end
      ST_PRE_VAL: begin
        data = cmd_q.pre_val;
        nxt  = phase_from(1'b0, lit_rem_q != '0, cmd_q.post_run, cmd_q.pad);
      end
      ST_LIT_HDR: begin
        data = chunk - 8'd1;
        nxt  = ST_LIT_DATA;
        if (advance) begin
          lit_rem_d   = lit_rem_q - chunk;
          chunk_rem_d = chunk;
        end
      end
      ST_LIT_DATA: begin
        data = lit_rd_data_i;
        if (chunk_rem_q == 8'd1) begin
          nxt = phase_from(1'b0, lit_rem_q != '0, cmd_q.post_run, cmd_q.pad);
        end else begin
          nxt = ST_LIT_DATA;
        end
        if (advance) begin
          chunk_rem_d = chunk_rem_q - 8'd1;
          head_d      = head_q + 1'b1;
        end
      end
      ST_POST_HDR: begin
        data = run_header(cmd_q.post_len);
        nxt  = ST_POST_VAL;
      end
      ST_POST_VAL: begin
        data = cmd_q.cur_val;
        nxt  = phase_from(1'b0, 1'b0, 1'b0, cmd_q.pad);
      end
      ST_PAD: begin
        data = PAD_BYTE;
        nxt  = ST_IDLE;
      end
      default: begin
        byte_valid_o = 1'b0;
        state_d      = ST_IDLE;
      end
    endcase
    if (advance) begin
      state_d = nxt;
    end
  end

  assign byte_o.data     = data;
  assign byte_o.item_end = nxt == ST_IDLE;
  assign byte_o.seg_end  = (nxt == ST_IDLE) && cmd_q.seg_end;

  // read one ahead so the data byte is ready in the cycle it is sent
  assign lit_rd_addr_o = head_d[LIT_AW-1:0];
  assign lit_head_o    = head_q;

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    chunk_rem_q <= chunk_rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lit_rem_q <= '0;
      head_q    <= '0;
    end else begin
      state_q   <= state_d;
      lit_rem_q <= lit_rem_d;
      head_q    <= head_d;
    end
  end

endmodule

// ===== hw/rtl/pbrle_pack.sv =====
module pbrle_pack import pbrle_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  byte_valid_i,
  input  byte_t byte_i,
  output logic  byte_ready_o,
  output logic  empty,
  input  logic  pop,
  output res_t  res_o
);

  localparam int unsigned CW = $clog2(WORD_BYTES);

  res_t              entry_q [OUTQ_DEPTH];
  logic [OUTQ_AW:0]  wr_q, wr_d;
  logic [OUTQ_AW:0]  rd_q, rd_d;
  logic [OUTQ_AW:0]  level;
  logic              out_full;
  logic [63:0]       acc_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [63:0]       base;
  logic [63:0]       merged;
  logic [CW:0]       new_cnt;
  logic              take;
  logic              complete;
  logic              q_push;
  res_t              q_word;

  assign level        = wr_q - rd_q;
  assign out_full     = level == (OUTQ_AW+1)'(OUTQ_DEPTH);
  assign empty        = level == '0;
  assign res_o        = entry_q[rd_q[OUTQ_AW-1:0]];
  assign byte_ready_o = !out_full;
  assign take         = byte_valid_i && byte_ready_o;

  // a fresh word starts from zero so unused high bytes read as zero
  assign base    = (cnt_q == '0) ? '0 : acc_q;
  assign new_cnt = {1'b0, cnt_q} + 1'b1;

  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      merged[8*i +: 8] = (cnt_q == CW'(i)) ? byte_i.data : base[8*i +: 8];
    end
  end

  assign complete = byte_i.item_end || (new_cnt == (CW+1)'(WORD_BYTES));
  assign q_push   = take && complete;
  assign cnt_d    = take ? (complete ? '0 : new_cnt[CW-1:0]) : cnt_q;

  always_comb begin
    q_word.word         = merged;
    q_word.count        = 4'(new_cnt);
    q_word.burst_last   = byte_i.item_end;
    q_word.segment_done = byte_i.seg_end;
  end

  assign wr_d = q_push ? wr_q + 1'b1 : wr_q;
  assign rd_d = (pop && !empty) ? rd_q + 1'b1 : rd_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q <= merged;
    end
    if (q_push) begin
      entry_q[wr_q[OUTQ_AW-1:0]] <= q_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== tb/sv/packbits_rle_segment_encoder_tb.sv =====
module packbits_rle_segment_encoder_tb;
  import pbrle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 40;

  // kinds of generated segment
  localparam int SEG_MIXED    = 0;
  localparam int SEG_LONG_RUN = 1;
  localparam int SEG_LITERALS = 2;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        push           = 1'b0;
  logic [7:0]  data_byte_i    = 8'h00;
  logic        segment_last_i = 1'b0;
  logic        pop            = 1'b0;
  logic        full;
  logic        empty;
  logic [63:0] out_word_o;
  logic [3:0]  out_count_o;
  logic        burst_last_o;
  logic        segment_done_o;

  packbits_rle_segment_encoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .segment_last_i (segment_last_i),
    .empty          (empty),
    .pop            (pop),
    .out_word_o     (out_word_o),
    .out_count_o    (out_count_o),
    .burst_last_o   (burst_last_o),
    .segment_done_o (segment_done_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  int unsigned errors     = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned items_sent = 0;
  bit          no_idle    = 1'b0;

  // encoder state as seen by the predictor
  logic [8:0]  prev_byte  = 9'h100;
  int unsigned run_len    = 0;
  logic [7:0]  lit_pending[$];
  logic        seg_parity = 1'b0;
  logic [7:0]  enc_bytes[$];

  res_t        expected_words[$];

  function automatic void emit_byte(input logic [7:0] v);
    enc_bytes.push_back(v);
    seg_parity = ~seg_parity;
  endfunction

  function automatic void stash_previous();
    if (lit_pending.size() < MAX_CHUNK + 2) lit_pending.push_back(prev_byte[7:0]);
  endfunction

  function automatic void flush_literal_chunk();
    int unsigned n;
    n = (lit_pending.size() < MAX_CHUNK) ? lit_pending.size() : MAX_CHUNK;
    if (n == 0) return;
    emit_byte(8'(n - 1));
    repeat (n) emit_byte(lit_pending.pop_front());
  endfunction

  function automatic void flush_run_chunk();
    int unsigned n;
    n = (run_len < MAX_CHUNK) ? run_len : MAX_CHUNK;
    emit_byte(8'(257 - n));
    emit_byte(prev_byte[7:0]);
    run_len -= n;
  endfunction

  function automatic void predict_words(input logic [7:0] b, input logic last);
    int unsigned nres;
    int unsigned cnt;
    res_t        w;
    enc_bytes.delete();
    if ({1'b0, b} == prev_byte) begin
      run_len++;
      if (run_len > 2 && lit_pending.size() > 0) begin
        while (lit_pending.size() > 0) flush_literal_chunk();
      end else if (run_len > MAX_CHUNK) begin
        flush_run_chunk();
      end
    end else begin
      if (run_len == 1) begin
        stash_previous();
      end else if (run_len == 2) begin
        stash_previous();
        stash_previous();
      end else begin
        while (run_len > 0) flush_run_chunk();
      end
      while (lit_pending.size() > MAX_CHUNK) flush_literal_chunk();
      prev_byte = {1'b0, b};
      run_len   = 1;
    end
    if (last) begin
      // a lone byte at close goes out as a literal, a pair as a replicate
      if (run_len < 2) begin
        while (run_len > 0) begin
          stash_previous();
          run_len--;
        end
      end
      while (lit_pending.size() > 0) flush_literal_chunk();
      while (run_len > 0) flush_run_chunk();
      if (seg_parity) emit_byte(8'h00);
      prev_byte  = 9'h100;
      run_len    = 0;
      lit_pending.delete();
      seg_parity = 1'b0;
    end
    nres = (enc_bytes.size() + 7) / 8;
    for (int k = 0; k < nres; k++) begin
      w   = '0;
      cnt = 0;
      while (cnt < 8 && enc_bytes.size() > 0) begin
        w.word[8*cnt +: 8] = enc_bytes.pop_front();
        cnt++;
      end
      w.count        = 4'(cnt);
      w.burst_last   = (k == nres - 1);
      w.segment_done = (k == nres - 1) && last;
      expected_words.push_back(w);
    end
  endfunction

  // called just after a falling edge, returns just after the one that follows the byte's acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    push           <= 1'b1;
    data_byte_i    <= b;
    segment_last_i <= last;
    do @(posedge clk_i); while (full);
    predict_words(b, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_segment(input int kind, input bit close);
    logic [7:0] seg[$];
    logic [7:0] v;
    int         len;
    v = 8'($urandom);
    case (kind)
      SEG_LONG_RUN: begin
        repeat ($urandom_range(0, 3)) begin
          v = v + 8'($urandom_range(1, 255));
          seg.push_back(v);
        end
        v = v + 8'($urandom_range(1, 255));
        repeat ($urandom_range(126, 140)) seg.push_back(v);
      end
      SEG_LITERALS: begin
        // runs of one or two only, so literals pile up past a full chunk
        len = $urandom_range(126, 134);
        while (seg.size() < len) begin
          v = v + 8'($urandom_range(1, 255));
          repeat ($urandom_range(1, 2)) seg.push_back(v);
        end
      end
      default: begin
        repeat ($urandom_range(1, 10)) begin
          v   = 8'($urandom);
          len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 2) : $urandom_range(3, 8);
          repeat (len) seg.push_back(v);
        end
      end
    endcase
    foreach (seg[i]) send_byte(seg[i], close && (i == seg.size() - 1));
  endtask

  function automatic int pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return SEG_LONG_RUN;
    if (r == 1) return SEG_LITERALS;
    return SEG_MIXED;
  endfunction

  task automatic test_edge_values();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // pair at close
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // run of three flushes the pending literals
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);
    // odd length, padded
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
  endtask

  task automatic test_chunk_limits();
    send_segment(SEG_LONG_RUN, 1'b1);
    send_segment(SEG_LITERALS, 1'b0);
    send_segment(SEG_MIXED, 1'b1);
  endtask

  task automatic test_random_segments();
    int unsigned start;
    start = items_sent;
    while (items_sent - start < 30) send_segment(pick_kind(), $urandom_range(0, 5) != 0);
    send_segment(SEG_MIXED, 1'b1);
  endtask

  task automatic test_full_rate();
    int unsigned start;
    no_idle = 1'b1;
    start   = items_sent;
    while (items_sent - start < 25) send_segment(SEG_MIXED, $urandom_range(0, 3) != 0);
    send_segment(SEG_MIXED, 1'b1);
  endtask

  // receiver side, stalls in bursts
  int unsigned pop_stall = 0;
  always @(negedge clk_i) begin
    if (!no_idle && pop_stall == 0 && $urandom_range(0, 5) == 0)
      pop_stall = $urandom_range(1, 14);
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_words
    res_t e;
    if (rst_ni && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $error("word with no expectation: out_word %h out_count %0d", out_word_o, out_count_o);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_word_o !== e.word) begin
          $error("out_word mismatch: expected %h, actual %h", e.word, out_word_o);
          errors++;
        end
        if (out_count_o !== e.count) begin
          $error("out_count mismatch: expected %0d, actual %0d", e.count, out_count_o);
          errors++;
        end
        if (burst_last_o !== e.burst_last) begin
          $error("burst_last mismatch: expected %b, actual %b", e.burst_last, burst_last_o);
          errors++;
        end
        if (segment_done_o !== e.segment_done) begin
          $error("segment_done mismatch: expected %b, actual %b", e.segment_done,
                 segment_done_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** packbits_rle_segment_encoder: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_edge_values();
    test_chunk_limits();
    test_random_segments();
    test_full_rate();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("** packbits_rle_segment_encoder: PASSED **");
    end else begin
      $display("** packbits_rle_segment_encoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pbrle_pkg.sv
hw/rtl/pbrle_lit_buf.sv
hw/rtl/pbrle_front.sv
hw/rtl/pbrle_cmd_fifo.sv
hw/rtl/pbrle_back.sv
hw/rtl/pbrle_pack.sv
hw/rtl/packbits_rle_segment_encoder.sv
tb/sv/packbits_rle_segment_encoder_tb.sv
